// ===== sv/sbe_pkg.sv =====
// Shared types and constants of the stack bytecode executor.
`default_nettype none
package sbe_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int CALL_DEPTH_DEF  = 16;
  localparam int DATA_WIDTH_DEF  = 32;
  localparam int PC_WIDTH_DEF    = 16;
  localparam int IMM_WIDTH       = 32;
  localparam int WIDE_STEP       = 2;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [4:0] {
    OP_PUSH = 5'd0,  OP_POP = 5'd1,  OP_NEG = 5'd2,  OP_NOT = 5'd3,
    OP_ADD  = 5'd4,  OP_SUB = 5'd5,  OP_MUL = 5'd6,  OP_DIV = 5'd7,
    OP_MOD  = 5'd8,  OP_CALL = 5'd9, OP_RET = 5'd10,
    OP_LT   = 5'd19, OP_LE = 5'd20,  OP_GT = 5'd21,  OP_GE = 5'd22,
    OP_NE   = 5'd24, OP_HALT = 5'd25
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_UNDERFLOW = 3'd1, ST_OVERFLOW = 3'd2, ST_TYPE = 3'd3,
    ST_DIV_ZERO = 3'd4, ST_UNSUPPORTED = 3'd5, ST_HALTED = 3'd6, ST_CALL_OVF = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    TAG_INT = 2'd0, TAG_NIL = 2'd1, TAG_BOOL = 2'd2, TAG_OBJ = 2'd3
  } tag_t;

  typedef enum logic [3:0] {
    C_PUSH, C_POP, C_NEG, C_NOT, C_ALU, C_CMP, C_CALL, C_RET, C_HALT, C_BAD
  } op_class_t;

  typedef enum logic [3:0] {
    A_ADD, A_SUB, A_MUL, A_DIV, A_MOD, A_LT, A_LE, A_GT, A_GE, A_NE
  } alu_op_t;

  typedef enum logic [1:0] {MD_MUL, MD_DIV, MD_MOD} md_op_t;

  typedef enum logic [1:0] {B_IDLE, B_EXEC, B_MD} back_state_t;

  typedef struct packed {
    op_class_t cls;
    alu_op_t   alu;
  } cmd_ctl_t;

endpackage
`default_nettype wire

// ===== sv/sbe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module sbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== sv/sbe_front.sv =====
// Front end: takes requests, decodes the opcode and queues them for the back end.
`default_nettype none
module sbe_front #(
  parameter int PC_WIDTH = sbe_pkg::PC_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [PC_WIDTH-1:0]                  in_pc,
  input  wire logic [4:0]                           in_opcode,
  input  wire logic signed [sbe_pkg::IMM_WIDTH-1:0] in_immediate,
  output logic                                      q_valid,
  input  wire logic                                 q_pop,
  output logic [PC_WIDTH-1:0]                       q_pc,
  output logic signed [sbe_pkg::IMM_WIDTH-1:0]      q_imm,
  output sbe_pkg::cmd_ctl_t                         q_ctl
);
  import sbe_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [PC_WIDTH-1:0]         pc_q  [QUEUE_DEPTH];
  logic signed [IMM_WIDTH-1:0] imm_q [QUEUE_DEPTH];
  cmd_ctl_t                    ctl_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push;
  cmd_ctl_t      dec;

  always_comb begin
    dec.cls = C_BAD;
    dec.alu = A_ADD;
    case (in_opcode)
      OP_PUSH: dec.cls = C_PUSH;
      OP_POP:  dec.cls = C_POP;
      OP_NEG:  dec.cls = C_NEG;
      OP_NOT:  dec.cls = C_NOT;
      OP_ADD:  begin dec.cls = C_ALU; dec.alu = A_ADD; end
      OP_SUB:  begin dec.cls = C_ALU; dec.alu = A_SUB; end
      OP_MUL:  begin dec.cls = C_ALU; dec.alu = A_MUL; end
      OP_DIV:  begin dec.cls = C_ALU; dec.alu = A_DIV; end
      OP_MOD:  begin dec.cls = C_ALU; dec.alu = A_MOD; end
      OP_LT:   begin dec.cls = C_CMP; dec.alu = A_LT; end
      OP_LE:   begin dec.cls = C_CMP; dec.alu = A_LE; end
      OP_GT:   begin dec.cls = C_CMP; dec.alu = A_GT; end
      OP_GE:   begin dec.cls = C_CMP; dec.alu = A_GE; end
      OP_NE:   begin dec.cls = C_CMP; dec.alu = A_NE; end
      OP_CALL: dec.cls = C_CALL;
      OP_RET:  dec.cls = C_RET;
      OP_HALT: dec.cls = C_HALT;
      default: dec.cls = C_BAD;
    endcase
  end

  assign in_ready = (cnt_r != CW'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_pc     = pc_q[rd_ptr_r];
  assign q_imm    = imm_q[rd_ptr_r];
  assign q_ctl    = ctl_q[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? PW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? PW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = CW'(cnt_r + CW'(push) - CW'(q_pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      pc_q[wr_ptr_r]  <= in_pc;
      imm_q[wr_ptr_r] <= in_immediate;
      ctl_q[wr_ptr_r] <= dec;
    end
  end
endmodule
`default_nettype wire

// ===== sv/sbe_muldiv.sv =====
// Bit-serial multiply and signed truncating divide/modulo, one bit per cycle.
`default_nettype none
module sbe_muldiv #(
  parameter int DATA_WIDTH = sbe_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire sbe_pkg::md_op_t       op,
  input  wire logic [DATA_WIDTH-1:0] a,
  input  wire logic [DATA_WIDTH-1:0] b,
  output logic                       done,
  output logic [DATA_WIDTH-1:0]      result
);
  import sbe_pkg::*;

  localparam int W     = DATA_WIDTH;
  localparam int CNT_W = $clog2(DATA_WIDTH + 1);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W:0]       acc_r;
  logic [W-1:0]     x_r, y_r;
  md_op_t           op_r;
  logic             negq_r, negr_r;
  logic [W:0]       rem_s;
  logic             fits;
  logic [W-1:0]     abs_a, abs_b;

  assign abs_a = a[W-1] ? W'(-a) : a;
  assign abs_b = b[W-1] ? W'(-b) : b;
  assign rem_s = {acc_r[W-1:0], x_r[W-1]};
  assign fits  = (rem_s >= {1'b0, y_r});
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && cnt_r == CNT_W'(1)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r  <= CNT_W'(DATA_WIDTH);
      op_r   <= op;
      acc_r  <= '0;
      negq_r <= a[W-1] ^ b[W-1];
      negr_r <= a[W-1];
      if (op == MD_MUL) begin
        x_r <= b;
        y_r <= a;
      end else begin
        x_r <= abs_a;
        y_r <= abs_b;
      end
    end else if (busy_r) begin
      cnt_r <= CNT_W'(cnt_r - 1'b1);
      if (op_r == MD_MUL) begin
        acc_r <= {1'b0, W'(acc_r[W-1:0] + (x_r[0] ? y_r : '0))};
        x_r   <= x_r >> 1;
        y_r   <= y_r << 1;
      end else begin
        // restoring step: quotient bits shift in at the bottom of x
        acc_r <= fits ? (rem_s - {1'b0, y_r}) : rem_s;
        x_r   <= {x_r[W-2:0], fits};
      end
    end
  end

  always_comb begin
    case (op_r)
      MD_MUL:  result = acc_r[W-1:0];
      MD_DIV:  result = negq_r ? W'(-x_r) : x_r;
      default: result = negr_r ? W'(-acc_r[W-1:0]) : acc_r[W-1:0];
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/sbe_back.sv =====
// Back end: operand and call stacks, instruction execution and result register.
`default_nettype none
module sbe_back #(
  parameter int STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF,
  parameter int CALL_DEPTH  = sbe_pkg::CALL_DEPTH_DEF,
  parameter int DATA_WIDTH  = sbe_pkg::DATA_WIDTH_DEF,
  parameter int PC_WIDTH    = sbe_pkg::PC_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 q_valid,
  output logic                                      q_pop,
  input  wire logic [PC_WIDTH-1:0]                  q_pc,
  input  wire logic signed [sbe_pkg::IMM_WIDTH-1:0] q_imm,
  input  wire sbe_pkg::cmd_ctl_t                    q_ctl,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [2:0]                                out_status,
  output logic [PC_WIDTH-1:0]                       out_next_pc,
  output logic [1:0]                                out_top_tag,
  output logic signed [DATA_WIDTH-1:0]              out_top_value,
  output logic [$clog2(STACK_DEPTH+1)-1:0]          out_stack_depth,
  output logic [$clog2(CALL_DEPTH+1)-1:0]           out_frame_depth
);
  import sbe_pkg::*;

  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int FP_W = $clog2(CALL_DEPTH + 1);
  localparam int CAW  = $clog2(CALL_DEPTH);
  localparam int SW   = DATA_WIDTH + 2;
  localparam int CW   = PC_WIDTH + SP_W;

  back_state_t state_r, state_nxt;
  logic [SP_W-1:0]       sp_r, sp_nxt;
  logic [FP_W-1:0]       fp_r, fp_nxt;
  logic                  halted_r, halted_nxt;
  tag_t                  tos_tag_r, tos_tag_nxt;
  logic [DATA_WIDTH-1:0] tos_data_r, tos_data_nxt;
  logic [PC_WIDTH-1:0]         cur_pc_r;
  logic signed [IMM_WIDTH-1:0] cur_imm_r;
  cmd_ctl_t                    cur_ctl_r;
  logic                        out_valid_r;

  logic          s_we, s_re;
  logic [AW-1:0] s_waddr, s_raddr;
  logic [SW-1:0] s_wdata, s_rdata;
  logic           c_we;
  logic [CW-1:0]  c_wdata, c_rdata;

  logic                  md_start, md_done, md_need;
  md_op_t                md_op;
  logic [DATA_WIDTH-1:0] md_res;

  tag_t                  sec_tag;
  logic [DATA_WIDTH-1:0] sec_data, push_val, bin_res, neg_val;
  logic [PC_WIDTH-1:0]   pc1, pc2, ret_pc;
  logic [SP_W-1:0]       base;
  logic                  lt, gt, out_free, commit, cmd_done;
  status_t               st;
  logic [PC_WIDTH-1:0]   npc;

  // stack and call writes land only at the commit edge
  sbe_ram #(.WIDTH(SW), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk(clk), .we(s_we && commit), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
  );

  sbe_ram #(.WIDTH(CW), .DEPTH(CALL_DEPTH)) u_call_ram (
    .clk(clk), .we(c_we && commit), .waddr(CAW'(fp_r)), .wdata(c_wdata),
    .re(s_re), .raddr(CAW'(fp_r - 1'b1)), .rdata(c_rdata)
  );

  sbe_muldiv #(.DATA_WIDTH(DATA_WIDTH)) u_muldiv (
    .clk(clk), .rst_n(rst_n), .start(md_start), .op(md_op),
    .a(sec_data), .b(tos_data_r), .done(md_done), .result(md_res)
  );

  // second entry from the top is read while the request is taken
  assign s_re     = (state_r == B_IDLE) && q_valid;
  assign s_raddr  = AW'(sp_r - SP_W'(2));
  assign q_pop    = s_re;
  assign sec_tag  = tag_t'(s_rdata[DATA_WIDTH+1:DATA_WIDTH]);
  assign sec_data = s_rdata[DATA_WIDTH-1:0];
  assign push_val = DATA_WIDTH'(cur_imm_r);
  assign neg_val  = DATA_WIDTH'(-tos_data_r);
  assign pc1      = PC_WIDTH'(cur_pc_r + 1'b1);
  assign pc2      = PC_WIDTH'(cur_pc_r + PC_WIDTH'(WIDE_STEP));
  assign ret_pc   = c_rdata[CW-1:SP_W];
  // the base frame's entry is never written; its base is zero
  assign base     = (fp_r == FP_W'(1)) ? '0 : c_rdata[SP_W-1:0];
  assign lt       = $signed(sec_data) < $signed(tos_data_r);
  assign gt       = $signed(tos_data_r) < $signed(sec_data);
  assign out_free = !out_valid_r || out_ready;
  assign md_need  = (cur_ctl_r.alu == A_MUL) || (cur_ctl_r.alu == A_DIV)
                    || (cur_ctl_r.alu == A_MOD);

  always_comb begin
    case (cur_ctl_r.alu)
      A_ADD:   bin_res = DATA_WIDTH'(sec_data + tos_data_r);
      A_SUB:   bin_res = DATA_WIDTH'(sec_data - tos_data_r);
      A_LT:    bin_res = DATA_WIDTH'(lt);
      A_LE:    bin_res = DATA_WIDTH'(!gt);
      A_GT:    bin_res = DATA_WIDTH'(gt);
      A_GE:    bin_res = DATA_WIDTH'(!lt);
      A_NE:    bin_res = DATA_WIDTH'(sec_data != tos_data_r);
      default: bin_res = md_res;
    endcase
    case (cur_ctl_r.alu)
      A_DIV:   md_op = MD_DIV;
      A_MOD:   md_op = MD_MOD;
      default: md_op = MD_MUL;
    endcase
  end

  // execution of the current request
  always_comb begin
    st           = ST_OK;
    npc          = cur_pc_r;
    sp_nxt       = sp_r;
    fp_nxt       = fp_r;
    halted_nxt   = halted_r;
    tos_tag_nxt  = tos_tag_r;
    tos_data_nxt = tos_data_r;
    s_we         = 1'b0;
    s_waddr      = AW'(sp_r - 1'b1);
    s_wdata      = {TAG_INT, tos_data_r};
    c_we         = 1'b0;
    c_wdata      = {pc2, sp_r};
    md_start     = 1'b0;
    if (halted_r) begin
      st = ST_HALTED;
    end else begin
      case (cur_ctl_r.cls)
        C_PUSH: begin
          if (sp_r == SP_W'(STACK_DEPTH)) begin
            st = ST_OVERFLOW;
          end else begin
            s_we         = 1'b1;
            s_waddr      = AW'(sp_r);
            s_wdata      = {TAG_INT, push_val};
            tos_tag_nxt  = TAG_INT;
            tos_data_nxt = push_val;
            sp_nxt       = SP_W'(sp_r + 1'b1);
            npc          = pc2;
          end
        end
        C_POP: begin
          if (sp_r == '0) begin
            st = ST_UNDERFLOW;
          end else begin
            tos_tag_nxt  = sec_tag;
            tos_data_nxt = sec_data;
            sp_nxt       = SP_W'(sp_r - 1'b1);
            npc          = pc1;
          end
        end
        C_NEG: begin
          if (sp_r == '0) begin
            st = ST_UNDERFLOW;
          end else begin
            s_we         = 1'b1;
            s_wdata      = {TAG_INT, neg_val};
            tos_tag_nxt  = TAG_INT;
            tos_data_nxt = neg_val;
            npc          = pc1;
          end
        end
        C_NOT: begin
          if (sp_r == '0) begin
            st = ST_UNDERFLOW;
          end else if (tos_tag_r != TAG_BOOL) begin
            st = ST_TYPE;
          end else begin
            s_we         = 1'b1;
            s_wdata      = {TAG_BOOL, DATA_WIDTH'(tos_data_r == '0)};
            tos_data_nxt = DATA_WIDTH'(tos_data_r == '0);
            npc          = pc1;
          end
        end
        C_ALU, C_CMP: begin
          if (sp_r < SP_W'(2)) begin
            st = ST_UNDERFLOW;
          end else if (cur_ctl_r.cls == C_ALU
                       && (sec_tag != TAG_INT || tos_tag_r != TAG_INT)) begin
            st = ST_TYPE;
          end else if ((cur_ctl_r.alu == A_DIV || cur_ctl_r.alu == A_MOD)
                       && tos_data_r == '0) begin
            st = ST_DIV_ZERO;
          end else if (md_need && state_r == B_EXEC) begin
            md_start = 1'b1;
          end else begin
            s_we         = 1'b1;
            s_waddr      = AW'(sp_r - SP_W'(2));
            tos_tag_nxt  = (cur_ctl_r.cls == C_CMP) ? TAG_BOOL : TAG_INT;
            s_wdata      = {tos_tag_nxt, bin_res};
            tos_data_nxt = bin_res;
            sp_nxt       = SP_W'(sp_r - 1'b1);
            npc          = pc1;
          end
        end
        C_CALL: begin
          if (fp_r == FP_W'(CALL_DEPTH)) begin
            st = ST_CALL_OVF;
          end else begin
            c_we   = 1'b1;
            fp_nxt = FP_W'(fp_r + 1'b1);
            npc    = PC_WIDTH'(cur_imm_r);
          end
        end
        C_RET: begin
          if (sp_r > base) begin
            s_we    = 1'b1;
            s_waddr = AW'(base);
            s_wdata = {tos_tag_r, tos_data_r};
            sp_nxt  = SP_W'(base + 1'b1);
          end
          if (fp_r <= FP_W'(1)) begin
            halted_nxt = 1'b1;
            st         = ST_HALTED;
          end else begin
            npc    = ret_pc;
            fp_nxt = FP_W'(fp_r - 1'b1);
          end
        end
        C_HALT: begin
          halted_nxt = 1'b1;
          st         = ST_HALTED;
        end
        default: st = ST_UNSUPPORTED;
      endcase
    end
  end

  assign cmd_done = ((state_r == B_EXEC) && !md_start) || ((state_r == B_MD) && md_done);
  assign commit   = cmd_done && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (q_valid) state_nxt = B_EXEC;
      B_EXEC: begin
        if (md_start) begin
          state_nxt = B_MD;
        end else if (commit) begin
          state_nxt = B_IDLE;
        end
      end
      B_MD:    if (commit) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      sp_r        <= '0;
      fp_r        <= FP_W'(1);
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= commit || (out_valid_r && !out_ready);
      if (commit) begin
        sp_r     <= sp_nxt;
        fp_r     <= fp_nxt;
        halted_r <= halted_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_re) begin
      cur_pc_r  <= q_pc;
      cur_imm_r <= q_imm;
      cur_ctl_r <= q_ctl;
    end
    if (commit) begin
      tos_tag_r       <= tos_tag_nxt;
      tos_data_r      <= tos_data_nxt;
      out_status      <= st;
      out_next_pc     <= npc;
      out_stack_depth <= sp_nxt;
      out_frame_depth <= fp_nxt;
      if (sp_nxt == '0) begin
        out_top_tag   <= TAG_NIL;
        out_top_value <= '0;
      end else begin
        out_top_tag   <= tos_tag_nxt;
        out_top_value <= tos_data_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

// ===== sv/stack_bytecode_executor.sv =====
// Top level of the stack bytecode executor.
// Runs one stack-machine instruction per request and returns one result per request.
// Input channel in_*: pc, opcode and immediate, taken when in_valid and in_ready are high.
// Output channel out_*: status, next pc, top-of-stack tag/value, stack and frame depth.
// A two-entry queue holds decoded requests ahead of execution; in_ready drops only
// when both entries wait on a busy back end or a held result.
// A request passes through the queue, the operand read and execute before its result.
// The back end takes no new request before the current one commits: the operand stack
// RAM read is followed by the execute/write step. Multiply, divide and modulo go through
// a bit-serial unit.
// When out_ready is low the finished result is held in the output register;
// execution of the next instruction waits only at its commit point.
// Reset: empty operand stack, base frame only, not halted, queue empty.
// After a halt every request reports the halted status until reset.
`default_nettype none
module stack_bytecode_executor #(
  parameter int STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF,
  parameter int CALL_DEPTH  = sbe_pkg::CALL_DEPTH_DEF,
  parameter int DATA_WIDTH  = sbe_pkg::DATA_WIDTH_DEF,
  parameter int PC_WIDTH    = sbe_pkg::PC_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [PC_WIDTH-1:0]                  in_pc,
  input  wire logic [4:0]                           in_opcode,
  input  wire logic signed [sbe_pkg::IMM_WIDTH-1:0] in_immediate,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [2:0]                                out_status,
  output logic [PC_WIDTH-1:0]                       out_next_pc,
  output logic [1:0]                                out_top_tag,
  output logic signed [DATA_WIDTH-1:0]              out_top_value,
  output logic [$clog2(STACK_DEPTH+1)-1:0]          out_stack_depth,
  output logic [$clog2(CALL_DEPTH+1)-1:0]           out_frame_depth
);
  import sbe_pkg::*;

  logic                        q_valid, q_pop;
  logic [PC_WIDTH-1:0]         q_pc;
  logic signed [IMM_WIDTH-1:0] q_imm;
  cmd_ctl_t                    q_ctl;

  sbe_front #(.PC_WIDTH(PC_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_pc(in_pc),
    .in_opcode(in_opcode), .in_immediate(in_immediate),
    .q_valid(q_valid), .q_pop(q_pop), .q_pc(q_pc), .q_imm(q_imm), .q_ctl(q_ctl)
  );

  sbe_back #(
    .STACK_DEPTH(STACK_DEPTH), .CALL_DEPTH(CALL_DEPTH),
    .DATA_WIDTH(DATA_WIDTH), .PC_WIDTH(PC_WIDTH)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_pop(q_pop), .q_pc(q_pc), .q_imm(q_imm), .q_ctl(q_ctl),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_next_pc(out_next_pc), .out_top_tag(out_top_tag),
    .out_top_value(out_top_value), .out_stack_depth(out_stack_depth),
    .out_frame_depth(out_frame_depth)
  );

`ifndef NO_ASSERTIONS
  a_empty_nil: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stack_depth == '0 |-> out_top_tag == TAG_NIL && out_top_value == '0)
    else $error("empty stack must show nil");

  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_stack_depth <= ($clog2(STACK_DEPTH+1))'(STACK_DEPTH)
                  && out_frame_depth != '0
                  && out_frame_depth <= ($clog2(CALL_DEPTH+1))'(CALL_DEPTH))
    else $error("stack or frame depth out of range");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_status == ST_HALTED ##1 out_valid
      |-> out_status == ST_HALTED)
    else $error("halt did not persist");
`endif
endmodule
`default_nettype wire
